// ----- rtl/ffta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_pkg: shared types and constants of the first-fit heap allocator
// Holds the chunk record, operation, status and cell command codes, states and sizes.
// ----------------------------------------------------------------------------
package ffta_pkg;

    localparam int MAX_CHUNKS   = 64;
    localparam int IDX_W        = $clog2(MAX_CHUNKS);
    localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);
    localparam int OWNER_W      = 22;
    localparam int SIZE_W       = 24;
    localparam int HEAP_W       = 25;
    localparam logic [SIZE_W-1:0] HEADER_BYTES = 24'd12;
    localparam logic [HEAP_W-1:0] HEAP_MIN     = 25'd16;
    localparam logic [HEAP_W-1:0] HEAP_MAX     = 25'd16777216;
    localparam logic [HEAP_W-1:0] HEAP_RESET   = 25'd65536;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_LEFT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_OUT   = 2'd2
    } state_t;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  length;
        logic [SIZE_W-1:0]  start;
    } chunk_t;

    // Per-cell control: shift command and a record written on CMD_WRITE.
    typedef struct packed {
        cmd_t   cmd;
        chunk_t wdata;
    } cell_ctrl_t;

endpackage : ffta_pkg
`default_nettype wire

// ----- rtl/first_fit_tagged_heap_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An item is accepted in IDLE, all cells are compared and the chain is
// updated in EXEC, and the result is offered from the next cycle on.
// A new request is taken only once the last result has been taken;
// the parallel compare over all cells and the single shift step set the pace.
// Reset: heap_size reads 65536, and a boot step after reset loads cell 0
// with a free chunk of 65520 bytes at offset 0; s_tready stays low during it.
// ----------------------------------------------------------------------------
// first_fit_tagged_heap_allocator: first-fit chunk allocator top level
// A chain of chunk cells with a parallel first-match search and a controller.
// ----------------------------------------------------------------------------
module first_fit_tagged_heap_allocator
    import ffta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: [21:0] owner_id, [45:22] alloc_size, [47:46] zero
    input  wire logic [47:0] s_tdata,
    // tuser: [1:0] operation
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: [23:0] data_offset
    output logic [23:0]      m_tdata,
    // tuser: [1:0] status
    output logic [1:0]       m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration register: heap size, the only register at address 0.
    logic [HEAP_W-1:0] heap_size_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= HEAP_RESET;
        end
        else if (psel && penable && pwrite && (paddr == 2'd0))
        begin
            heap_size_reg <= pwdata[HEAP_W-1:0];
        end
    end

    assign prdata = (paddr == 2'd0) ? {{(32-HEAP_W){1'b0}}, heap_size_reg} : 32'd0;

    // The request is latched in IDLE and executed in EXEC.
    state_t state_reg, state_next;
    op_t                op_reg;
    logic [OWNER_W-1:0] id_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         status_reg, status_next;
    logic [SIZE_W-1:0]  offset_reg, offset_next;

    // Set from reset until cell 0 has taken the reset chunk, then cleared.
    logic   boot_reg;
    chunk_t boot_rec;

    chunk_t     recs [MAX_CHUNKS];
    cell_ctrl_t ctrls [MAX_CHUNKS];

    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++)
        begin : g_cell
            chunk_t left_in, right_in;
            if (g == 0)
            begin : g_first
                assign left_in = recs[0];
            end
            else
            begin : g_mid
                assign left_in = recs[g-1];
            end
            if (g == MAX_CHUNKS - 1)
            begin : g_last
                assign right_in = recs[g];
            end
            else
            begin : g_notlast
                assign right_in = recs[g+1];
            end
            ffta_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrls[g]),
                .from_left  (left_in),
                .from_right (right_in),
                .rec        (recs[g])
            );
        end
    endgenerate

    // Parallel compare in every cell, then a first-match priority pick.
    logic [SIZE_W:0]   need;
    logic [MAX_CHUNKS-1:0] fit_hit, id_hit;
    logic              fit_found, id_found;
    logic [IDX_W-1:0]  fit_k, id_k;
    logic [IDX_W-1:0]  k;
    chunk_t            rec_k, rec_k1;
    logic              k1_valid;
    logic [HEAP_W-1:0] hs_sat;
    logic [SIZE_W-1:0] merged_len;

    assign need = {1'b0, size_reg} + {1'b0, HEADER_BYTES};

    always_comb
    begin
        for (int i = 0; i < MAX_CHUNKS; i++)
        begin
            fit_hit[i] = (i < count_reg) && (recs[i].owner == '0)
                       && ({1'b0, recs[i].length} >= need);
            id_hit[i]  = (i < count_reg) && (recs[i].owner == id_reg);
        end
    end

    always_comb
    begin
        fit_found = 1'b0;
        id_found  = 1'b0;
        fit_k     = '0;
        id_k      = '0;
        for (int i = MAX_CHUNKS - 1; i >= 0; i--)
        begin
            if (fit_hit[i])
            begin
                fit_found = 1'b1;
                fit_k     = IDX_W'(i);
            end
            if (id_hit[i])
            begin
                id_found = 1'b1;
                id_k     = IDX_W'(i);
            end
        end
    end

    assign k        = (op_reg == OP_ALLOC) ? fit_k : id_k;
    assign rec_k    = recs[k];
    assign rec_k1   = recs[(k == IDX_W'(MAX_CHUNKS - 1)) ? k : k + 1'b1];
    assign k1_valid = ({1'b0, k} + 1'b1) < count_reg;
    assign merged_len = rec_k.length + HEADER_BYTES + rec_k1.length;

    always_comb
    begin
        if (heap_size_reg < HEAP_MIN)      hs_sat = HEAP_MIN;
        else if (heap_size_reg > HEAP_MAX) hs_sat = HEAP_MAX;
        else                               hs_sat = heap_size_reg;
    end

    assign boot_rec = '{owner: '0, start: '0, length: SIZE_W'(HEAP_RESET - HEAP_MIN)};

    // Controller: next state, chain commands and result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        offset_next = offset_reg;
        for (int i = 0; i < MAX_CHUNKS; i++)
        begin
            ctrls[i].cmd   = CMD_HOLD;
            ctrls[i].wdata = recs[i];
        end
        // The boot cycle loads the reset chunk into cell 0.
        if (boot_reg)
        begin
            ctrls[0].cmd   = CMD_WRITE;
            ctrls[0].wdata = boot_rec;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_OUT;
                status_next = ST_OK;
                offset_next = '0;
                case (op_reg)
                    OP_CLEAR:
                    begin
                        ctrls[0].cmd   = CMD_WRITE;
                        ctrls[0].wdata = '{owner: '0, start: '0,
                                           length: SIZE_W'(hs_sat - HEAP_MIN)};
                        count_next     = CNT_W'(1);
                    end
                    OP_ALLOC:
                    begin
                        if (!fit_found)
                        begin
                            status_next = ST_NO_FIT;
                        end
                        else if (count_reg >= CNT_W'(MAX_CHUNKS))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            offset_next = rec_k.start + HEADER_BYTES;
                            count_next  = count_reg + 1'b1;
                            for (int i = 0; i < MAX_CHUNKS; i++)
                            begin
                                if (i == k)
                                begin
                                    ctrls[i].cmd   = CMD_WRITE;
                                    ctrls[i].wdata = '{owner: id_reg,
                                        length: size_reg, start: rec_k.start};
                                end
                                else if (i == k + 1)
                                begin
                                    ctrls[i].cmd   = CMD_WRITE;
                                    ctrls[i].wdata = '{owner: '0,
                                        length: rec_k.length - need[SIZE_W-1:0],
                                        start: rec_k.start + need[SIZE_W-1:0]};
                                end
                                else if (i > k + 1 && i <= count_reg)
                                begin
                                    ctrls[i].cmd = CMD_RIGHT;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (!id_found)
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            offset_next = rec_k.start + HEADER_BYTES;
                            if (op_reg == OP_FREE)
                            begin
                                ctrls[k].cmd         = CMD_WRITE;
                                ctrls[k].wdata.owner = '0;
                                if (k1_valid && rec_k1.owner == '0)
                                begin
                                    ctrls[k].wdata.length = merged_len;
                                    count_next = count_reg - 1'b1;
                                    for (int i = 0; i < MAX_CHUNKS; i++)
                                    begin
                                        if (i > k && i + 1 < count_reg)
                                        begin
                                            ctrls[i].cmd = CMD_LEFT;
                                        end
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        offset_reg <= offset_next;
        if (state_reg == S_IDLE && s_tvalid && s_tready)
        begin
            op_reg   <= op_t'(s_tuser);
            id_reg   <= s_tdata[OWNER_W-1:0];
            size_reg <= s_tdata[OWNER_W+SIZE_W-1:OWNER_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) boot_reg <= 1'b1;
        else        boot_reg <= 1'b0;
    end

    assign s_tready = (state_reg == S_IDLE) && !boot_reg;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = offset_reg;
    assign m_tuser  = status_reg;

    // Assertions.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_CHUNKS))
        else $error("chunk count out of range");
    a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> m_tvalid)
        else $error("result not offered after execution");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_tready)
        else $error("request taken while busy");
    a_boot_only_once: assert property (@(posedge clk) disable iff (!rst_n)
        $past(boot_reg) == 1'b0 |-> !boot_reg)
        else $error("boot write repeated");

endmodule : first_fit_tagged_heap_allocator
`default_nettype wire

// ----- rtl/ffta_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_cell: one slot of the chunk chain
// Holds a chunk record and shifts it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module ffta_cell
    import ffta_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  cell_ctrl_t      ctrl,
    input  chunk_t          from_left,
    input  chunk_t          from_right,
    output chunk_t          rec
);

    chunk_t rec_reg;
    chunk_t rec_next;

    always_comb
    begin
        case (ctrl.cmd)
            CMD_WRITE: rec_next = ctrl.wdata;
            CMD_RIGHT: rec_next = from_left;
            CMD_LEFT:  rec_next = from_right;
            default:   rec_next = rec_reg;
        endcase
    end

    // The whole record clears on reset; cell 0 is then loaded by the top level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule : ffta_cell
`default_nettype wire

// ----- bench/first_fit_tagged_heap_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_tagged_heap_allocator_test: self-checking bench of the allocator
// A directed table, a table-full run, a receiver hold-off run, then random
// allocate, free, look-up and clear traffic, is driven through the request
// stream. Every result is compared with a chunk-table predictor kept inside
// this bench. The heap size register is changed between phases while idle.
// ----------------------------------------------------------------------------
module first_fit_tagged_heap_allocator_test;
    import ffta_pkg::*;

    localparam int ID_POOL = 12;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] offset;
    } alloc_result_t;

    typedef struct {
        op_t         op;
        logic [21:0] id;
        logic [23:0] size;
        bit          fixed;
        status_t     want_status;
        logic [23:0] want_offset;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: the address-ordered chunk table and the heap size.
    logic [21:0] chunk_owner [MAX_CHUNKS];
    logic [23:0] chunk_len   [MAX_CHUNKS];
    logic [23:0] chunk_base  [MAX_CHUNKS];
    int          chunk_total;
    logic [24:0] heap_bytes;

    alloc_result_t pending_results[$];
    int   failures;
    int   results_seen;
    int   full_seen;
    int   nofit_seen;
    bit   long_hold;
    bit   stall_enable;

    first_fit_tagged_heap_allocator dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("first_fit_tagged_heap_allocator verification failed");
        $finish;
    end

    // Clear rebuilds one free chunk from the saturated heap size.
    function automatic void rebuild_heap();
        logic [24:0] hs;
        hs = heap_bytes;
        if (hs < HEAP_MIN) hs = HEAP_MIN;
        if (hs > HEAP_MAX) hs = HEAP_MAX;
        chunk_owner[0] = '0;
        chunk_base[0]  = '0;
        chunk_len[0]   = 24'(hs - 25'd16);
        chunk_total    = 1;
    endfunction

    function automatic int owner_slot(logic [21:0] id);
        for (int i = 0; i < chunk_total; i++)
            if (chunk_owner[i] == id) return i;
        return -1;
    endfunction

    // Applies one request to the chunk table and returns its expected result.
    function automatic alloc_result_t heap_apply(op_t op, logic [21:0] id,
                                                 logic [23:0] size);
        alloc_result_t r;
        logic [24:0]   need;
        int            k;
        r = '0;
        k = -1;
        case (op)
            OP_CLEAR: rebuild_heap();
            OP_ALLOC:
            begin
                need = {1'b0, size} + 25'd12;
                for (int i = 0; i < chunk_total && k < 0; i++)
                    if (chunk_owner[i] == 0 && {1'b0, chunk_len[i]} >= need) k = i;
                if (k < 0)
                    r.status = ST_NO_FIT;
                else if (chunk_total >= MAX_CHUNKS)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = chunk_total; i > k + 1; i--)
                    begin
                        chunk_owner[i] = chunk_owner[i-1];
                        chunk_len[i]   = chunk_len[i-1];
                        chunk_base[i]  = chunk_base[i-1];
                    end
                    chunk_owner[k+1] = '0;
                    chunk_len[k+1]   = 24'({1'b0, chunk_len[k]} - need);
                    chunk_base[k+1]  = 24'({1'b0, chunk_base[k]} + need);
                    chunk_owner[k]   = id;
                    chunk_len[k]     = size;
                    chunk_total++;
                    r.offset = chunk_base[k] + 24'd12;
                end
            end
            OP_FREE:
            begin
                k = owner_slot(id);
                if (k < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    chunk_owner[k] = '0;
                    r.offset = chunk_base[k] + 24'd12;
                    if (k + 1 < chunk_total && chunk_owner[k+1] == 0)
                    begin
                        chunk_len[k] = chunk_len[k] + 24'd12 + chunk_len[k+1];
                        for (int i = k + 1; i + 1 < chunk_total; i++)
                        begin
                            chunk_owner[i] = chunk_owner[i+1];
                            chunk_len[i]   = chunk_len[i+1];
                            chunk_base[i]  = chunk_base[i+1];
                        end
                        chunk_total--;
                    end
                end
            end
            default:
            begin
                k = owner_slot(id);
                if (k < 0) r.status = ST_NOT_FOUND;
                else r.offset = chunk_base[k] + 24'd12;
            end
        endcase
        return r;
    endfunction

    // Offers one request and holds it until the block takes it.
    task automatic send_request(op_t op, logic [21:0] id, logic [23:0] size);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, size, id};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(heap_apply(op, id, size));
    endtask

    task automatic idle_gap(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Sends one request, sometimes followed by a random idle gap.
    task automatic random_request(op_t op, logic [21:0] id, logic [23:0] size);
        send_request(op, id, size);
        if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 6));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_heap_size(logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= value;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        heap_bytes = value[24:0];
    endtask

    // Receiver: a random stall pattern, plus one long hold-off on request.
    initial
    begin
        int hold;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                hold = 0;
                while (hold < 200)
                begin
                    @(posedge clk);
                    hold++;
                end
                long_hold = 1'b0;
            end
            m_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Result checker: compares every taken result with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result status=%0d offset=%0d", m_tuser, m_tdata);
                failures++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.status == ST_FULL) full_seen++;
                if (exp_r.status == ST_NO_FIT) nofit_seen++;
                if (m_tuser !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
                    failures++;
                end
                if (m_tdata !== exp_r.offset)
                begin
                    $error("data_offset: expected %0d, actual %0d",
                           exp_r.offset, m_tdata);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        table_row_t   plan[$];
        table_row_t   row;
        alloc_result_t pre;
        int           dropped;
        int           guard;
        logic [31:0]  sizes [4];
        logic [21:0]  pick;

        failures = 0;
        results_seen = 0;
        full_seen = 0;
        nofit_seen = 0;
        long_hold = 1'b0;
        stall_enable = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        heap_bytes = HEAP_RESET;
        for (int i = 0; i < MAX_CHUNKS; i++)
        begin
            chunk_owner[i] = '0;
            chunk_len[i]   = '0;
            chunk_base[i]  = '0;
        end
        rebuild_heap();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Fixed rows are read straight off the reset heap.
        plan = '{
            '{OP_LOOKUP, 22'd0,       24'd0,        1'b1, ST_OK,        24'd12},
            '{OP_LOOKUP, 22'd5,       24'd0,        1'b1, ST_NOT_FOUND, 24'd0},
            '{OP_FREE,   22'd5,       24'd0,        1'b1, ST_NOT_FOUND, 24'd0},
            '{OP_ALLOC,  22'd1,       24'hFFFFFF,   1'b1, ST_NO_FIT,    24'd0},
            '{OP_ALLOC,  22'h3FFFFF,  24'd0,        1'b1, ST_OK,        24'd12},
            '{OP_ALLOC,  22'd0,       24'd100,      1'b0, ST_OK,        24'd0},
            '{OP_ALLOC,  22'd7,       24'd40,       1'b0, ST_OK,        24'd0},
            '{OP_LOOKUP, 22'd7,       24'd0,        1'b0, ST_OK,        24'd0},
            '{OP_FREE,   22'h3FFFFF,  24'd0,        1'b0, ST_OK,        24'd0},
            '{OP_FREE,   22'd0,       24'd0,        1'b0, ST_OK,        24'd0},
            '{OP_ALLOC,  22'd9,       24'd65256,    1'b0, ST_OK,        24'd0},
            '{OP_FREE,   22'd9,       24'd0,        1'b0, ST_OK,        24'd0},
            '{OP_FREE,   22'd7,       24'd0,        1'b0, ST_OK,        24'd0},
            '{OP_CLEAR,  22'h2AAAAA,  24'h555555,   1'b1, ST_OK,        24'd0},
            '{OP_ALLOC,  22'h155555,  24'd65508,    1'b1, ST_OK,        24'd12},
            '{OP_LOOKUP, 22'd0,       24'd0,        1'b1, ST_OK,        24'd65532},
            '{OP_FREE,   22'h155555,  24'hAAAAAA,   1'b1, ST_OK,        24'd12},
            '{OP_CLEAR,  22'd0,       24'd0,        1'b1, ST_OK,        24'd0}
        };
        foreach (plan[i])
        begin
            row = plan[i];
            send_request(row.op, row.id, row.size);
            if (row.fixed)
            begin
                pre = pending_results[$];
                if (pre.status != row.want_status || pre.offset != row.want_offset)
                begin
                    $error("directed row %0d: table value disagrees with predictor", i);
                    failures++;
                end
            end
        end
        drain_results();

        // Table full: sixty-three tiny allocations, then one more.
        for (int i = 1; i <= MAX_CHUNKS; i++)
            send_request(OP_ALLOC, 22'(i), 24'd1);
        send_request(OP_FREE, 22'd3, 24'd0);
        send_request(OP_CLEAR, 22'd0, 24'd0);
        drain_results();

        // Pressure: the receiver holds off while requests keep coming.
        long_hold = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(OP_LOOKUP, 22'(i), 24'd0);
        drain_results();

        // Random phases under several heap sizes, extremes included.
        sizes = '{32'd16, 32'd16777216, 32'h1FFFFFF, 32'd300};
        stall_enable = 1'b1;
        dropped = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
                write_heap_size(phase == 4 ? {7'd0, 25'($urandom)} : sizes[phase-1]);
            send_request(OP_CLEAR, 22'($urandom), 24'($urandom));
            for (int n = 0; n < 256; n++)
            begin
                pick = 22'($urandom_range(0, ID_POOL));
                if ($urandom_range(0, 19) == 0) pick = 22'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                        random_request(OP_ALLOC, pick,
                            ($urandom_range(0, 15) == 0) ? 24'($urandom)
                                                         : 24'($urandom_range(0, 600)));
                    4, 5, 6: random_request(OP_FREE, pick, 24'($urandom));
                    7, 8:    random_request(OP_LOOKUP, pick, 24'($urandom));
                    default:
                        if ($urandom_range(0, 9) == 0)
                            random_request(OP_CLEAR, pick, 24'($urandom));
                        else
                            random_request(OP_ALLOC, 22'($urandom), 24'($urandom_range(0, 40)));
                endcase
            end
            drain_results();
        end

        guard = 0;
        while (pending_results.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        $display("Covered %0d results across five heap sizes, with %0d table-full",
                 results_seen, full_seen);
        $display("and %0d no-fit answers, under random stalls and one long hold-off.",
                 nofit_seen);
        if (failures == 0 && pending_results.size() == 0)
            $display("first_fit_tagged_heap_allocator verification clean");
        else
            $display("first_fit_tagged_heap_allocator verification failed");
        $finish;
    end

endmodule
